/* hdl/prq_pkg.sv */
// Shared types and constants for the priority ready queue.
// No dependencies; used by prq_cell, prq_chain and priority_ready_queue.
`default_nettype none

package prq_pkg;

    // pool size; one cell per slot in each queue's row
    localparam int SLOTS  = 32;
    localparam int SLOT_W = 5;
    localparam int PRIO_W = 8;

    typedef enum logic [1:0] {
        ACT_INS_PRIO   = 2'd0,
        ACT_INS_TAIL   = 2'd1,
        ACT_REMOVE     = 2'd2,
        ACT_BAD_METHOD = 2'd3
    } prq_action_t;

    typedef enum logic [2:0] {
        STAT_INS_EMPTY  = 3'd0,
        STAT_INSERTED   = 3'd1,
        STAT_REMOVED    = 3'd2,
        STAT_BAD_METHOD = 3'd3,
        STAT_BAD_SLOT   = 3'd4
    } prq_status_t;

    typedef enum logic [1:0] {
        QM_NONE  = 2'd0,
        QM_READY = 2'd1,
        QM_INIT  = 2'd2
    } prq_member_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } prq_cell_op_t;

    typedef struct packed {
        logic                     valid;
        logic [SLOT_W-1:0]        slot;
        logic signed [PRIO_W-1:0] prio;
    } prq_entry_t;

    localparam prq_entry_t EMPTY_ENTRY = '0;

    // command from the sequencer to one row of cells
    typedef struct packed {
        logic        eval;
        logic        apply;
        prq_action_t act;
        prq_entry_t  key;
    } prq_chain_cmd_t;

endpackage

`default_nettype wire

/* hdl/priority_ready_queue.sv */
// Priority ready queue: two rows of cells (ready and init, each filled by
// priority or at the tail as the action asks) plus slot membership flags and
// the sequencer. Uses prq_pkg, prq_chain. Each transfer steps through the
// accepting cycle, evaluation of all cells of the row against the key, the
// row shift, and the result load. The next transfer is taken as soon as the
// result is registered, even while that result still waits on m_axis_tready;
// the result of that next transfer then waits until the earlier one has gone.
`default_nettype none

module priority_ready_queue (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // action[1:0], slot[6:2], priority_req[14:7], zero
    input  wire  [1:0]  s_axis_tuser,  // queue_sel[0], slot_present[1]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[2:0], head_slot[7:3], head_valid[8], zero
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_RESULT
    } state_t;

    state_t                             state_reg, state_next;
    prq_pkg::prq_action_t               act_reg, act_next;
    logic                               sel_reg, sel_next;
    logic [prq_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic                               present_reg, present_next;
    logic signed [prq_pkg::PRIO_W-1:0]  prio_reg, prio_next;
    prq_pkg::prq_status_t               status_reg, status_next;
    logic                               chg_en_reg, chg_en_next;
    logic                               chg_q_reg, chg_q_next;
    logic                               m_valid_reg, m_valid_next;
    logic [15:0]                        m_data_reg, m_data_next;

    prq_pkg::prq_member_t slot_queue_reg [prq_pkg::SLOTS];
    prq_pkg::prq_member_t sq_cur;

    prq_pkg::prq_chain_cmd_t cmd_ready, cmd_init;
    prq_pkg::prq_entry_t     head_ready, head_init, head_sel;
    prq_pkg::prq_entry_t     key;

    logic s_xfer;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign sq_cur   = slot_queue_reg[slot_reg];
    assign head_sel = sel_reg ? head_init : head_ready;

    assign key.valid = 1'b1;
    assign key.slot  = slot_reg;
    assign key.prio  = prio_reg;

    always_comb begin
        cmd_ready.eval  = (state_reg == S_EVAL);
        cmd_ready.apply = (state_reg == S_APPLY) && chg_en_reg && !chg_q_reg;
        cmd_ready.act   = act_reg;
        cmd_ready.key   = key;
        cmd_init.eval   = (state_reg == S_EVAL);
        cmd_init.apply  = (state_reg == S_APPLY) && chg_en_reg && chg_q_reg;
        cmd_init.act    = act_reg;
        cmd_init.key    = key;
    end

    prq_chain u_ready (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_ready),
        .head    (head_ready)
    );

    prq_chain u_init (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_init),
        .head    (head_init)
    );

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        sel_next     = sel_reg;
        slot_next    = slot_reg;
        present_next = present_reg;
        prio_next    = prio_reg;
        status_next  = status_reg;
        chg_en_next  = chg_en_reg;
        chg_q_next   = chg_q_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    act_next     = prq_pkg::prq_action_t'(s_axis_tdata[1:0]);
                    slot_next    = s_axis_tdata[6:2];
                    prio_next    = s_axis_tdata[14:7];
                    sel_next     = s_axis_tuser[0];
                    present_next = s_axis_tuser[1];
                    state_next   = S_EVAL;
                end
            end
            S_EVAL: begin
                chg_en_next = 1'b0;
                chg_q_next  = sel_reg;
                if (!present_reg) begin
                    status_next = prq_pkg::STAT_BAD_SLOT;
                end else if (act_reg == prq_pkg::ACT_BAD_METHOD) begin
                    status_next = prq_pkg::STAT_BAD_METHOD;
                end else if (act_reg == prq_pkg::ACT_REMOVE) begin
                    // removal acts on the queue holding the slot, not on queue_sel
                    if (sq_cur == prq_pkg::QM_READY || sq_cur == prq_pkg::QM_INIT) begin
                        status_next = prq_pkg::STAT_REMOVED;
                        chg_en_next = 1'b1;
                        chg_q_next  = (sq_cur == prq_pkg::QM_INIT);
                    end else begin
                        status_next = prq_pkg::STAT_BAD_SLOT;
                    end
                end else if (sq_cur != prq_pkg::QM_NONE) begin
                    status_next = prq_pkg::STAT_BAD_SLOT;
                end else begin
                    status_next = head_sel.valid ? prq_pkg::STAT_INSERTED
                                                 : prq_pkg::STAT_INS_EMPTY;
                    chg_en_next = 1'b1;
                end
                state_next = S_APPLY;
            end
            S_APPLY: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, head_sel.valid,
                                    head_sel.valid ? head_sel.slot : {prq_pkg::SLOT_W{1'b0}},
                                    status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            chg_en_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            chg_en_reg  <= chg_en_next;
        end
        act_reg     <= act_next;
        sel_reg     <= sel_next;
        slot_reg    <= slot_next;
        present_reg <= present_next;
        prio_reg    <= prio_next;
        status_reg  <= status_next;
        chg_q_reg   <= chg_q_next;
        m_data_reg  <= m_data_next;
    end

    // membership flags, updated with the row shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < prq_pkg::SLOTS; i++) begin
                slot_queue_reg[i] <= prq_pkg::QM_NONE;
            end
        end else if (state_reg == S_APPLY && chg_en_reg) begin
            if (act_reg == prq_pkg::ACT_REMOVE) begin
                slot_queue_reg[slot_reg] <= prq_pkg::QM_NONE;
            end else begin
                slot_queue_reg[slot_reg] <= chg_q_reg ? prq_pkg::QM_INIT : prq_pkg::QM_READY;
            end
        end
    end

    a_seq_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_EVAL) ##1 (state_reg == S_APPLY) ##1 (state_reg == S_RESULT))
        else $error("sequencer left its fixed step order");

    a_insert_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && chg_en_reg && act_reg != prq_pkg::ACT_REMOVE &&
         chg_q_reg == sel_reg) |=> head_sel.valid)
        else $error("selected queue empty after an insert into it");

    a_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && !chg_en_reg) |=> ($stable(head_ready) && $stable(head_init)))
        else $error("queue head moved on a rejected transfer");

    a_remove_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && chg_en_reg && act_reg == prq_pkg::ACT_REMOVE)
        |=> (slot_queue_reg[slot_reg] == prq_pkg::QM_NONE))
        else $error("removed slot still marked as queued");

endmodule

`default_nettype wire

/* hdl/prq_cell.sv */
// One cell of a queue row: holds one entry, flags itself against the key,
// and takes the new entry or a neighbour's entry on command. Uses prq_pkg.
`default_nettype none

module prq_cell (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  prq_pkg::prq_cell_op_t  op,
    input  prq_pkg::prq_action_t   act,
    input  prq_pkg::prq_entry_t    key,
    input  prq_pkg::prq_entry_t    prev_entry,
    input  prq_pkg::prq_entry_t    next_entry,
    output prq_pkg::prq_entry_t    entry,
    output logic                   flag
);

    logic                              valid_reg, valid_next;
    logic [prq_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic signed [prq_pkg::PRIO_W-1:0] prio_reg, prio_next;

    always_comb begin
        case (act)
            // new entry goes in front of the first lower priority or free cell
            prq_pkg::ACT_INS_PRIO: flag = !valid_reg || (prio_reg < key.prio);
            prq_pkg::ACT_INS_TAIL: flag = !valid_reg;
            prq_pkg::ACT_REMOVE:   flag = valid_reg && (slot_reg == key.slot);
            default:               flag = 1'b0;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        prio_next  = prio_reg;
        case (op)
            prq_pkg::CELL_LOAD_NEW: begin
                valid_next = 1'b1;
                slot_next  = key.slot;
                prio_next  = key.prio;
            end
            prq_pkg::CELL_FROM_PREV: begin
                valid_next = prev_entry.valid;
                slot_next  = prev_entry.slot;
                prio_next  = prev_entry.prio;
            end
            prq_pkg::CELL_FROM_NEXT: begin
                valid_next = next_entry.valid;
                slot_next  = next_entry.slot;
                prio_next  = next_entry.prio;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        slot_reg <= slot_next;
        prio_reg <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.slot  = slot_reg;
    assign entry.prio  = prio_reg;

endmodule

`default_nettype wire

/* hdl/prq_chain.sv */
// One queue as a row of prq_cell, head in cell 0. Registers the cell flags,
// then finds the first flagged cell and shifts the row. Uses prq_pkg, prq_cell.
`default_nettype none

module prq_chain (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  prq_pkg::prq_chain_cmd_t cmd,
    output prq_pkg::prq_entry_t     head
);

    prq_pkg::prq_entry_t   cell_entry [prq_pkg::SLOTS];
    prq_pkg::prq_cell_op_t cell_op    [prq_pkg::SLOTS];
    logic [prq_pkg::SLOTS-1:0] flags;
    logic [prq_pkg::SLOTS-1:0] cond_reg, cond_next;
    logic [prq_pkg::SLOTS-1:0] pos_oh;
    logic [prq_pkg::SLOTS-1:0] at_or_after;

    localparam logic [prq_pkg::SLOTS-1:0] ONE_V = {{(prq_pkg::SLOTS-1){1'b0}}, 1'b1};

    for (genvar i = 0; i < prq_pkg::SLOTS; i++) begin : g_cell
        prq_pkg::prq_entry_t prev_e;
        prq_pkg::prq_entry_t next_e;

        if (i == 0) begin : g_first
            assign prev_e = prq_pkg::EMPTY_ENTRY;
        end else begin : g_mid_prev
            assign prev_e = cell_entry[i-1];
        end

        if (i == prq_pkg::SLOTS - 1) begin : g_last
            assign next_e = prq_pkg::EMPTY_ENTRY;
        end else begin : g_mid_next
            assign next_e = cell_entry[i+1];
        end

        prq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (cell_op[i]),
            .act        (cmd.act),
            .key        (cmd.key),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (cell_entry[i]),
            .flag       (flags[i])
        );
    end

    // lowest set flag, and the mask of cells from it to the tail
    assign pos_oh      = cond_reg & (~cond_reg + ONE_V);
    assign at_or_after = ~(pos_oh - ONE_V);

    always_comb begin
        for (int i = 0; i < prq_pkg::SLOTS; i++) begin
            cell_op[i] = prq_pkg::CELL_HOLD;
            if (cmd.apply) begin
                if (cmd.act == prq_pkg::ACT_REMOVE) begin
                    if (at_or_after[i]) cell_op[i] = prq_pkg::CELL_FROM_NEXT;
                end else if (pos_oh[i]) begin
                    cell_op[i] = prq_pkg::CELL_LOAD_NEW;
                end else if (at_or_after[i]) begin
                    cell_op[i] = prq_pkg::CELL_FROM_PREV;
                end
            end
        end
    end

    assign cond_next = cmd.eval ? flags : cond_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond_reg <= '0;
        end else begin
            cond_reg <= cond_next;
        end
    end

    assign head = cell_entry[0];

endmodule

`default_nettype wire
